/* sv/mos_pkg.sv */
package mos_pkg;

    localparam int MOTOR_COUNT  = 4;
    // Power of two: the average is an arithmetic shift of the window sum.
    localparam int WINDOW_DEPTH = 8;
    localparam int SLOT_W       = $clog2(WINDOW_DEPTH);

    localparam int Q_W      = 16;               // Q8.8 command / offset
    localparam int SUM_W    = Q_W + SLOT_W;     // window sum
    localparam int V_W      = Q_W + 1;          // average plus offset
    localparam int MAG_W    = 15;               // |v| <= 25600
    localparam int DUTY_W   = 8;
    localparam int TOTAL_W  = 17;

    localparam int CLAMP_Q88 = 25600;           // 100.0 percent in Q8.8

    // duty = floor(mag * 255 / 25600) = floor(floor(mag * 51 / 1024) / 5)
    localparam int DUTY_MUL       = 51;
    localparam int DUTY_PRE_SHIFT = 10;
    localparam int PRE_W          = MAG_W + 6;
    localparam int TQ_W           = 11;         // mag * 51 / 1024 <= 1275
    // floor(t / 5) as (t * ceil(2^18 / 5)) >> 18, exact for t < 2^11
    localparam int DIV5_MUL       = 52429;
    localparam int DIV5_SHIFT     = 18;
    localparam int DIV5_W         = TQ_W + 16;

    localparam logic signed [V_W-1:0] V_MAX = V_W'(CLAMP_Q88);
    localparam logic signed [V_W-1:0] V_MIN = V_W'(-CLAMP_Q88);

    typedef logic signed [Q_W-1:0]   t_q88;
    typedef logic signed [SUM_W-1:0] t_sum;
    typedef logic [MAG_W-1:0]        t_mag;
    typedef logic [TQ_W-1:0]         t_tq;
    typedef logic [DUTY_W-1:0]       t_duty;
    typedef logic [TOTAL_W-1:0]      t_total;

endpackage

/* sv/mos_window.sv */
module mos_window (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_load,
    input  mos_pkg::t_q88  i_cmd [mos_pkg::MOTOR_COUNT],
    input  mos_pkg::t_q88  i_off [mos_pkg::MOTOR_COUNT],
    output mos_pkg::t_sum  o_sum [mos_pkg::MOTOR_COUNT],
    output mos_pkg::t_q88  o_off [mos_pkg::MOTOR_COUNT]
);
    import mos_pkg::*;

    t_q88              r_win [WINDOW_DEPTH][MOTOR_COUNT];
    t_sum              r_sum [MOTOR_COUNT];
    t_sum              n_sum [MOTOR_COUNT];
    t_q88              r_off [MOTOR_COUNT];
    logic [SLOT_W-1:0] r_slot;
    logic [SLOT_W-1:0] n_slot;

    // oldest entry leaves the sum, newest enters
    always_comb begin
        for (int m = 0; m < MOTOR_COUNT; m++) begin
            n_sum[m] = r_sum[m] - SUM_W'(r_win[r_slot][m]) + SUM_W'(i_cmd[m]);
        end
        n_slot = (r_slot == SLOT_W'(WINDOW_DEPTH - 1)) ? '0 : r_slot + 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int s = 0; s < WINDOW_DEPTH; s++) begin
                for (int m = 0; m < MOTOR_COUNT; m++) begin
                    r_win[s][m] <= '0;
                end
            end
            for (int m = 0; m < MOTOR_COUNT; m++) begin
                r_sum[m] <= '0;
            end
            r_slot <= '0;
        end else if (i_load) begin
            for (int m = 0; m < MOTOR_COUNT; m++) begin
                r_win[r_slot][m] <= i_cmd[m];
                r_sum[m]         <= n_sum[m];
            end
            r_slot <= n_slot;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_off <= i_off;
        end
    end

    assign o_sum = r_sum;
    assign o_off = r_off;

endmodule

/* sv/mos_clamp.sv */
module mos_clamp (
    input  logic           i_clk,
    input  logic           i_load,
    input  mos_pkg::t_sum  i_sum [mos_pkg::MOTOR_COUNT],
    input  mos_pkg::t_q88  i_off [mos_pkg::MOTOR_COUNT],
    output logic           o_fwd [mos_pkg::MOTOR_COUNT],
    output mos_pkg::t_mag  o_mag [mos_pkg::MOTOR_COUNT],
    output mos_pkg::t_tq   o_tq  [mos_pkg::MOTOR_COUNT]
);
    import mos_pkg::*;

    t_q88                    avg  [MOTOR_COUNT];
    logic signed [V_W-1:0]   v    [MOTOR_COUNT];
    logic signed [V_W-1:0]   vc   [MOTOR_COUNT];
    logic signed [V_W-1:0]   vabs [MOTOR_COUNT];
    logic [PRE_W-1:0]        pre  [MOTOR_COUNT];
    logic                    n_fwd [MOTOR_COUNT];
    t_mag                    n_mag [MOTOR_COUNT];
    t_tq                     n_tq  [MOTOR_COUNT];
    logic                    r_fwd [MOTOR_COUNT];
    t_mag                    r_mag [MOTOR_COUNT];
    t_tq                     r_tq  [MOTOR_COUNT];

    always_comb begin
        for (int m = 0; m < MOTOR_COUNT; m++) begin
            // floored average
            avg[m] = Q_W'(i_sum[m] >>> SLOT_W);
            v[m]   = V_W'(avg[m]) + V_W'(i_off[m]);
            if (v[m] > V_MAX) begin
                vc[m] = V_MAX;
            end else if (v[m] < V_MIN) begin
                vc[m] = V_MIN;
            end else begin
                vc[m] = v[m];
            end
            vabs[m]  = vc[m][V_W-1] ? -vc[m] : vc[m];
            n_mag[m] = vabs[m][MAG_W-1:0];
            n_fwd[m] = !vc[m][V_W-1] && (vc[m] != '0);
            pre[m]   = PRE_W'(n_mag[m]) * PRE_W'(DUTY_MUL);
            n_tq[m]  = pre[m][DUTY_PRE_SHIFT +: TQ_W];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_fwd <= n_fwd;
            r_mag <= n_mag;
            r_tq  <= n_tq;
        end
    end

    assign o_fwd = r_fwd;
    assign o_mag = r_mag;
    assign o_tq  = r_tq;

endmodule

/* sv/mos_duty.sv */
module mos_duty (
    input  logic             i_clk,
    input  logic             i_load,
    input  logic             i_fwd [mos_pkg::MOTOR_COUNT],
    input  mos_pkg::t_mag    i_mag [mos_pkg::MOTOR_COUNT],
    input  mos_pkg::t_tq     i_tq  [mos_pkg::MOTOR_COUNT],
    output logic             o_fwd  [mos_pkg::MOTOR_COUNT],
    output mos_pkg::t_duty   o_duty [mos_pkg::MOTOR_COUNT],
    output mos_pkg::t_total  o_total
);
    import mos_pkg::*;

    logic [DIV5_W-1:0] prod   [MOTOR_COUNT];
    t_duty             n_duty [MOTOR_COUNT];
    t_total            n_total;
    logic              r_fwd  [MOTOR_COUNT];
    t_duty             r_duty [MOTOR_COUNT];
    t_total            r_total;

    always_comb begin
        n_total = '0;
        for (int m = 0; m < MOTOR_COUNT; m++) begin
            // divide by 5 via reciprocal
            prod[m]   = DIV5_W'(i_tq[m]) * DIV5_W'(DIV5_MUL);
            n_duty[m] = prod[m][DIV5_SHIFT +: DUTY_W];
            n_total   = n_total + TOTAL_W'(i_mag[m]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_fwd   <= i_fwd;
            r_duty  <= n_duty;
            r_total <= n_total;
        end
    end

    assign o_fwd   = r_fwd;
    assign o_duty  = r_duty;
    assign o_total = r_total;

endmodule

/* sv/motor_output_smoothing.sv */
// Four-motor command smoothing with PWM clamp.
//
// Input channel: i_in_valid / o_in_stall carry one beat per control period:
// four signed Q8.8 commands and four one-shot Q8.8 offsets. A beat is taken
// on a rising edge with i_in_valid high and o_in_stall low.
// Output channel: o_out_valid / i_out_stall carry one result beat per input
// beat: direction bits, 8-bit duties and the total effort.
//
// The result reaches the outputs through the window update, the clamp and
// scaling, and the duty and total registers, in that order.
// Throughput: one beat per cycle while i_out_stall stays low; each of the
// three stages advances when it is empty or the stage after it advances.
//
// Reset (synchronous, active low) clears the command window, the running
// sums, the write slot and all stage valid bits; the average ramps up from
// zero as the window fills. While i_out_stall is high the output beat holds;
// the two stages behind it keep filling, then o_in_stall rises.
module motor_output_smoothing (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_in_valid,
    output logic                   o_in_stall,
    input  mos_pkg::t_q88          i_command_a,
    input  mos_pkg::t_q88          i_command_b,
    input  mos_pkg::t_q88          i_command_c,
    input  mos_pkg::t_q88          i_command_d,
    input  mos_pkg::t_q88          i_offset_a,
    input  mos_pkg::t_q88          i_offset_b,
    input  mos_pkg::t_q88          i_offset_c,
    input  mos_pkg::t_q88          i_offset_d,
    output logic                   o_out_valid,
    input  logic                   i_out_stall,
    output logic                   o_forward_a,
    output logic                   o_forward_b,
    output logic                   o_forward_c,
    output logic                   o_forward_d,
    output mos_pkg::t_duty         o_duty_a,
    output mos_pkg::t_duty         o_duty_b,
    output mos_pkg::t_duty         o_duty_c,
    output mos_pkg::t_duty         o_duty_d,
    output mos_pkg::t_total        o_total_effort
);
    import mos_pkg::*;

    logic   r_v1;
    logic   r_v2;
    logic   r_v3;
    logic   ld1;
    logic   ld2;
    logic   ld3;
    logic   accept;

    t_q88   cmd      [MOTOR_COUNT];
    t_q88   off      [MOTOR_COUNT];
    t_sum   s1_sum   [MOTOR_COUNT];
    t_q88   s1_off   [MOTOR_COUNT];
    logic   s2_fwd   [MOTOR_COUNT];
    t_mag   s2_mag   [MOTOR_COUNT];
    t_tq    s2_tq    [MOTOR_COUNT];
    logic   s3_fwd   [MOTOR_COUNT];
    t_duty  s3_duty  [MOTOR_COUNT];

    assign ld3    = !r_v3 || !i_out_stall;
    assign ld2    = !r_v2 || ld3;
    assign ld1    = !r_v1 || ld2;
    assign accept = i_in_valid && ld1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            if (ld1) begin
                r_v1 <= i_in_valid;
            end
            if (ld2) begin
                r_v2 <= r_v1;
            end
            if (ld3) begin
                r_v3 <= r_v2;
            end
        end
    end

    assign cmd[0] = i_command_a;
    assign cmd[1] = i_command_b;
    assign cmd[2] = i_command_c;
    assign cmd[3] = i_command_d;
    assign off[0] = i_offset_a;
    assign off[1] = i_offset_b;
    assign off[2] = i_offset_c;
    assign off[3] = i_offset_d;

    mos_window u_window (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (accept),
        .i_cmd   (cmd),
        .i_off   (off),
        .o_sum   (s1_sum),
        .o_off   (s1_off)
    );

    mos_clamp u_clamp (
        .i_clk  (i_clk),
        .i_load (ld2),
        .i_sum  (s1_sum),
        .i_off  (s1_off),
        .o_fwd  (s2_fwd),
        .o_mag  (s2_mag),
        .o_tq   (s2_tq)
    );

    mos_duty u_duty (
        .i_clk   (i_clk),
        .i_load  (ld3),
        .i_fwd   (s2_fwd),
        .i_mag   (s2_mag),
        .i_tq    (s2_tq),
        .o_fwd   (s3_fwd),
        .o_duty  (s3_duty),
        .o_total (o_total_effort)
    );

    assign o_in_stall  = !ld1;
    assign o_out_valid = r_v3;

    assign o_forward_a = s3_fwd[0];
    assign o_forward_b = s3_fwd[1];
    assign o_forward_c = s3_fwd[2];
    assign o_forward_d = s3_fwd[3];
    assign o_duty_a    = s3_duty[0];
    assign o_duty_b    = s3_duty[1];
    assign o_duty_c    = s3_duty[2];
    assign o_duty_d    = s3_duty[3];

endmodule

/* tb/motor_output_smoothing_checker.sv */
module motor_output_smoothing_checker (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    input  logic            i_in_stall,
    input  mos_pkg::t_q88   i_command_a,
    input  mos_pkg::t_q88   i_command_b,
    input  mos_pkg::t_q88   i_command_c,
    input  mos_pkg::t_q88   i_command_d,
    input  mos_pkg::t_q88   i_offset_a,
    input  mos_pkg::t_q88   i_offset_b,
    input  mos_pkg::t_q88   i_offset_c,
    input  mos_pkg::t_q88   i_offset_d,
    input  logic            i_out_valid,
    input  logic            i_out_stall,
    input  logic            i_forward_a,
    input  logic            i_forward_b,
    input  logic            i_forward_c,
    input  logic            i_forward_d,
    input  mos_pkg::t_duty  i_duty_a,
    input  mos_pkg::t_duty  i_duty_b,
    input  mos_pkg::t_duty  i_duty_c,
    input  mos_pkg::t_duty  i_duty_d,
    input  mos_pkg::t_total i_total_effort,
    output int              o_fail_count,
    output int              o_pending
);

    timeunit 1ns;
    timeprecision 1ps;

    import mos_pkg::*;

    localparam int DUTY_FULL    = 255;
    localparam int REPORT_LIMIT = 10;

    typedef t_q88 [MOTOR_COUNT-1:0] t_quad;

    typedef struct packed {
        logic [MOTOR_COUNT-1:0]  forward;
        t_duty [MOTOR_COUNT-1:0] duty;
        t_total                  total;
    } t_drive;

    string motor_tag [MOTOR_COUNT] = '{"a", "b", "c", "d"};

    int     cmd_window [WINDOW_DEPTH][MOTOR_COUNT];
    int     window_sum [MOTOR_COUNT];
    int     slot;
    t_drive drive_expected [$];
    int     failures = 0;

    task automatic clear_window();
        for (int s = 0; s < WINDOW_DEPTH; s++) begin
            for (int m = 0; m < MOTOR_COUNT; m++) begin
                cmd_window[s][m] = 0;
            end
        end
        for (int m = 0; m < MOTOR_COUNT; m++) begin
            window_sum[m] = 0;
        end
        slot = 0;
    endtask

    // Slide the window by one beat and queue the drive it should produce.
    task automatic smooth_and_store(input t_quad cmds, input t_quad offs);
        t_drive want;
        int     c;
        int     v;
        int     mag;
        int     total;
        total = 0;
        for (int m = 0; m < MOTOR_COUNT; m++) begin
            c = $signed(cmds[m]);
            window_sum[m] = window_sum[m] - cmd_window[slot][m] + c;
            cmd_window[slot][m] = c;
            // arithmetic shift on a signed int floors toward minus infinity
            v = (window_sum[m] >>> SLOT_W) + int'($signed(offs[m]));
            if (v > CLAMP_Q88) begin
                v = CLAMP_Q88;
            end else if (v < -CLAMP_Q88) begin
                v = -CLAMP_Q88;
            end
            mag = (v < 0) ? -v : v;
            want.forward[m] = (v > 0);
            want.duty[m]    = t_duty'(mag * DUTY_FULL / CLAMP_Q88);
            total += mag;
        end
        want.total = t_total'(total);
        drive_expected.push_back(want);
        slot = (slot + 1) % WINDOW_DEPTH;
    endtask

    task automatic note_mismatch(input string field, input int want, input int seen);
        if (failures < REPORT_LIMIT) begin
            $display("%0t: %s mismatch: expected %0d, got %0d", $realtime, field, want, seen);
        end
        failures++;
    endtask

    task automatic check_result(input t_drive seen);
        t_drive want;
        if (drive_expected.size() == 0) begin
            if (failures < REPORT_LIMIT) begin
                $display("%0t: result beat with nothing expected", $realtime);
            end
            failures++;
        end else begin
            want = drive_expected.pop_front();
            for (int m = 0; m < MOTOR_COUNT; m++) begin
                if (seen.forward[m] !== want.forward[m]) begin
                    note_mismatch({"forward_", motor_tag[m]}, int'(want.forward[m]),
                                  int'(seen.forward[m]));
                end
                if (seen.duty[m] !== want.duty[m]) begin
                    note_mismatch({"duty_", motor_tag[m]}, int'(want.duty[m]),
                                  int'(seen.duty[m]));
                end
            end
            if (seen.total !== want.total) begin
                note_mismatch("total_effort", int'(want.total), int'(seen.total));
            end
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            clear_window();
            drive_expected.delete();
        end else begin
            // a result never belongs to the beat taken at the same edge
            if (i_out_valid && !i_out_stall) begin
                check_result({{i_forward_d, i_forward_c, i_forward_b, i_forward_a},
                              {i_duty_d, i_duty_c, i_duty_b, i_duty_a},
                              i_total_effort});
            end
            if (i_in_valid && !i_in_stall) begin
                smooth_and_store({i_command_d, i_command_c, i_command_b, i_command_a},
                                 {i_offset_d, i_offset_c, i_offset_b, i_offset_a});
            end
        end
        o_pending    <= drive_expected.size();
        o_fail_count <= failures;
    end

endmodule

/* tb/tb_motor_output_smoothing.sv */
module tb_motor_output_smoothing;

    timeunit 1ns;
    timeprecision 1ps;

    import mos_pkg::*;

    localparam int IDLE_PCT       = 31;
    localparam int RANDOM_BEATS   = 1880;
    localparam int WATCHDOG_LIMIT = 1000;
    localparam int DRAIN_CYCLES   = 8;
    localparam int HOLD_CYCLES    = 80;

    typedef t_q88 [MOTOR_COUNT-1:0] t_quad;

    logic   i_clk = 1'b0;
    logic   i_rst_n = 1'b0;
    logic   i_in_valid = 1'b0;
    logic   o_in_stall;
    t_q88   i_command_a = '0;
    t_q88   i_command_b = '0;
    t_q88   i_command_c = '0;
    t_q88   i_command_d = '0;
    t_q88   i_offset_a = '0;
    t_q88   i_offset_b = '0;
    t_q88   i_offset_c = '0;
    t_q88   i_offset_d = '0;
    logic   o_out_valid;
    logic   i_out_stall = 1'b0;
    logic   o_forward_a;
    logic   o_forward_b;
    logic   o_forward_c;
    logic   o_forward_d;
    t_duty  o_duty_a;
    t_duty  o_duty_b;
    t_duty  o_duty_c;
    t_duty  o_duty_d;
    t_total o_total_effort;

    int fail_count;
    int pending;
    int beats_sent = 0;
    int quiet_cycles = 0;

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    motor_output_smoothing DUT (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_command_a    (i_command_a),
        .i_command_b    (i_command_b),
        .i_command_c    (i_command_c),
        .i_command_d    (i_command_d),
        .i_offset_a     (i_offset_a),
        .i_offset_b     (i_offset_b),
        .i_offset_c     (i_offset_c),
        .i_offset_d     (i_offset_d),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_forward_a    (o_forward_a),
        .o_forward_b    (o_forward_b),
        .o_forward_c    (o_forward_c),
        .o_forward_d    (o_forward_d),
        .o_duty_a       (o_duty_a),
        .o_duty_b       (o_duty_b),
        .o_duty_c       (o_duty_c),
        .o_duty_d       (o_duty_d),
        .o_total_effort (o_total_effort)
    );

    motor_output_smoothing_checker u_checker (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .i_in_stall     (o_in_stall),
        .i_command_a    (i_command_a),
        .i_command_b    (i_command_b),
        .i_command_c    (i_command_c),
        .i_command_d    (i_command_d),
        .i_offset_a     (i_offset_a),
        .i_offset_b     (i_offset_b),
        .i_offset_c     (i_offset_c),
        .i_offset_d     (i_offset_d),
        .i_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .i_forward_a    (o_forward_a),
        .i_forward_b    (o_forward_b),
        .i_forward_c    (o_forward_c),
        .i_forward_d    (o_forward_d),
        .i_duty_a       (o_duty_a),
        .i_duty_b       (o_duty_b),
        .i_duty_c       (o_duty_c),
        .i_duty_d       (o_duty_d),
        .i_total_effort (o_total_effort),
        .o_fail_count   (fail_count),
        .o_pending      (pending)
    );

    function automatic t_quad motors4(input int a, input int b, input int c, input int d);
        return {t_q88'(d), t_q88'(c), t_q88'(b), t_q88'(a)};
    endfunction

    // Random gaps before each beat, except over a steady stretch in the middle.
    task automatic send_beat(input t_quad cmds, input t_quad offs);
        while (!(beats_sent >= 700 && beats_sent < 1000)
               && $urandom_range(99) < IDLE_PCT) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid  <= 1'b1;
        i_command_a <= cmds[0];
        i_command_b <= cmds[1];
        i_command_c <= cmds[2];
        i_command_d <= cmds[3];
        i_offset_a  <= offs[0];
        i_offset_b  <= offs[1];
        i_offset_c  <= offs[2];
        i_offset_d  <= offs[3];
        @(posedge i_clk);
        while (o_in_stall) begin
            @(posedge i_clk);
        end
        beats_sent++;
    endtask

    // Receiver: random stalls, a calm stretch, and two long hold-offs that
    // back the pipeline up into the input.
    initial begin
        int cycle_no = 0;
        int hold = 0;
        forever begin
            @(posedge i_clk);
            cycle_no++;
            if (cycle_no == 600 || cycle_no == 2400) begin
                hold = HOLD_CYCLES;
            end
            if (hold > 0) begin
                i_out_stall <= 1'b1;
                hold--;
            end else if (cycle_no >= 1200 && cycle_no < 1700) begin
                i_out_stall <= 1'b0;
            end else begin
                i_out_stall <= ($urandom_range(99) < IDLE_PCT);
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("FAILURE");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        t_quad cmds;
        t_quad offs;
        int    flavor;

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // negative sums floor: -1 in the window averages to -1
        send_beat(motors4(-1, -1, -1, -1), motors4(0, 0, 0, 0));
        send_beat(motors4(0, 0, 0, 0), motors4(0, 0, 0, 0));
        // window still ramping from reset
        send_beat(motors4(32767, -32768, 0, 1), motors4(0, 0, 0, 0));
        send_beat(motors4(32767, -32768, 256, -256), motors4(32767, -32768, 1, -1));
        send_beat(motors4(0, 0, 0, 0), motors4(25600, -25600, -25601, 25601));
        // flush the window so the value lands exactly on zero
        repeat (WINDOW_DEPTH) send_beat(motors4(0, 0, 0, 0), motors4(0, 0, 0, 0));
        send_beat(motors4(0, 0, 0, 0), motors4(1, -1, 101, -101));
        send_beat(motors4(0, 0, 0, 0), motors4(100, 25599, -25599, 0));
        // full window at the extremes, sums at their largest magnitude
        repeat (WINDOW_DEPTH) begin
            send_beat(motors4(32767, -32768, 32767, -32768), motors4(0, 0, -32768, 32767));
        end
        send_beat(motors4(16'h5555, 16'haaaa, 16'h5555, 16'haaaa),
                  motors4(16'haaaa, 16'h5555, 16'haaaa, 16'h5555));

        for (int n = 0; n < RANDOM_BEATS; n++) begin
            flavor = $urandom_range(9);
            for (int m = 0; m < MOTOR_COUNT; m++) begin
                // four flavors in ten draw commands near the clamp range so duties spread out
                if (flavor >= 4 && flavor < 8) begin
                    cmds[m] = t_q88'(int'($urandom_range(52000)) - 26000);
                    offs[m] = $urandom_range(1) ? t_q88'(int'($urandom_range(1000)) - 500)
                                                : t_q88'(0);
                end else begin
                    cmds[m] = t_q88'($urandom);
                    offs[m] = (flavor < 4) ? t_q88'($urandom) : t_q88'(0);
                end
            end
            send_beat(cmds, offs);
        end
        i_in_valid <= 1'b0;

        // let the last accepted beat reach the checker before polling it
        @(posedge i_clk);
        wait (pending == 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

/* motor_output_smoothing.f */
sv/mos_pkg.sv
sv/mos_window.sv
sv/mos_clamp.sv
sv/mos_duty.sv
sv/motor_output_smoothing.sv
tb/motor_output_smoothing_checker.sv
tb/tb_motor_output_smoothing.sv
